@@ rtl/ppeg_pkg.sv @@
// Shared types, constants and field layout for the pointer position event generator.
`default_nettype none
package ppeg_pkg;

  localparam int COORD_W          = 16;
  localparam int BTN_W            = 5;
  localparam int BTN_IDX_W        = 3;
  localparam int CFG_IDX_W        = 2;
  localparam int BUTTON_COUNT_DEF = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    EV_MOVE   = 2'd0,
    EV_SCROLL = 2'd1,
    EV_DOWN   = 2'd2,
    EV_UP     = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_RIGHT  = 2'd1,
    REG_CLIP_TOP    = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } cfg_reg_t;

  localparam coord_t CLIP_LEFT_RST   = 16'sd0;
  localparam coord_t CLIP_RIGHT_RST  = 16'sd1023;
  localparam coord_t CLIP_TOP_RST    = 16'sd0;
  localparam coord_t CLIP_BOTTOM_RST = 16'sd767;

endpackage
`default_nettype wire

@@ rtl/ppeg_clamp.sv @@
// Adds a relative motion to one cursor axis and clamps it, low bound first then high bound.
`default_nettype none
module ppeg_clamp (
  input  wire ppeg_pkg::coord_t pos,
  input  wire ppeg_pkg::coord_t delta,
  input  wire ppeg_pkg::coord_t lo,
  input  wire ppeg_pkg::coord_t hi,
  output ppeg_pkg::coord_t      res
);
  import ppeg_pkg::*;

  logic signed [COORD_W:0] sum;
  logic signed [COORD_W:0] after_lo;
  logic signed [COORD_W:0] lo_ext;
  logic signed [COORD_W:0] hi_ext;

  always_comb begin
    lo_ext   = {lo[COORD_W-1], lo};
    hi_ext   = {hi[COORD_W-1], hi};
    sum      = {pos[COORD_W-1], pos} + {delta[COORD_W-1], delta};
    after_lo = (sum < lo_ext) ? lo_ext : sum;
    // The high bound is applied last, so it wins when the bounds are inverted.
    res      = (after_lo > hi_ext) ? hi : after_lo[COORD_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/pointer_position_event_generator.sv @@
// Top level of the pointer position event generator: report intake, event queue and output register.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: move_x, move_y, wheel_move, buttons_pressed
//  out_    | out | out_tvalid/tready  | tdata: button_index, cursor_x, cursor_y, scroll_amount;
//          |     |                    | tuser: event_kind; tlast: last_of_run
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata (clip rectangle)
//
// A report's position update is done on entry; its events are then issued one per cycle while
// the output is not stalled, from a pending-event mask into a single output register.
// A report that causes no event only updates the button state.
// Reset (synchronous, active low) clears the position, the button state and the pending
// events, and restores the default clip rectangle.
// A stalled output holds its item; the next report is taken as soon as the last pending
// event of the current one has moved into the output register.
`default_nettype none
module pointer_position_event_generator #(
  parameter int BUTTON_COUNT = ppeg_pkg::BUTTON_COUNT_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // move_x[15:0], move_y[31:16], wheel_move[47:32], buttons_pressed[52:48], zeros above
  input  wire  [ppeg_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // button_index[2:0], cursor_x[18:3], cursor_y[34:19], scroll_amount[50:35], zeros above
  output logic [ppeg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // event_kind[1:0]
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast,
  input  wire                                  cfg_we,
  input  wire  [ppeg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ppeg_pkg::COORD_W-1:0]         cfg_wdata
);
  import ppeg_pkg::*;

  localparam int BTN_N  = (BUTTON_COUNT < BTN_W) ? BUTTON_COUNT : BTN_W;
  localparam int PEND_W = BTN_N + 2;
  localparam int SEL_W  = $clog2(PEND_W);

  // Clip rectangle.
  coord_t clip_left_r, clip_right_r, clip_top_r, clip_bottom_r;

  // Cursor and button state.
  coord_t            pos_x_r, pos_y_r;
  coord_t            new_x, new_y;
  logic [BTN_W-1:0]  prev_btn_r;

  // Events of the report in hand: bit 0 move, bit 1 scroll, bit 2+i button i.
  logic [PEND_W-1:0] pend_r, pend_nxt, pend_left, in_mask;
  logic [BTN_N-1:0]  down_r;
  coord_t            wheel_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  event_kind_t       out_kind_r;
  logic [BTN_IDX_W-1:0] out_btn_r;
  coord_t            out_x_r, out_y_r, out_scroll_r;
  logic              out_last_r;

  coord_t            in_dx, in_dy, in_wheel;
  logic [BTN_W-1:0]  in_btn;
  logic              in_acc, emit;
  logic [SEL_W-1:0]  sel;
  event_kind_t       ev_kind;
  logic [BTN_IDX_W-1:0] ev_btn;
  coord_t            ev_scroll;

  assign in_dx    = in_tdata[COORD_W-1:0];
  assign in_dy    = in_tdata[2*COORD_W-1:COORD_W];
  assign in_wheel = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_btn   = in_tdata[3*COORD_W+BTN_W-1:3*COORD_W];

  ppeg_clamp u_clamp_x (
    .pos   (pos_x_r),
    .delta (in_dx),
    .lo    (clip_left_r),
    .hi    (clip_right_r),
    .res   (new_x)
  );

  ppeg_clamp u_clamp_y (
    .pos   (pos_y_r),
    .delta (in_dy),
    .lo    (clip_top_r),
    .hi    (clip_bottom_r),
    .res   (new_y)
  );

  // Lowest pending event goes next.
  always_comb begin
    sel = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  always_comb begin
    ev_btn    = '0;
    ev_scroll = '0;
    if (sel == SEL_W'(0)) begin
      ev_kind = EV_MOVE;
    end else if (sel == SEL_W'(1)) begin
      ev_kind   = EV_SCROLL;
      ev_scroll = wheel_r;
    end else begin
      ev_btn  = BTN_IDX_W'(sel - SEL_W'(2));
      ev_kind = down_r[ev_btn] ? EV_DOWN : EV_UP;
    end
  end

  always_comb begin
    emit      = (pend_r != '0) && (!out_valid_r || out_tready);
    pend_left = pend_r;
    if (emit) begin
      pend_left[sel] = 1'b0;
    end
    in_tready = (pend_left == '0);
    in_acc    = in_tvalid && in_tready;
    in_mask   = {(in_btn[BTN_N-1:0] ^ prev_btn_r[BTN_N-1:0]),
                 (in_wheel != '0), ((in_dx != '0) || (in_dy != '0))};
    pend_nxt  = in_acc ? in_mask : pend_left;
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_right_r  <= CLIP_RIGHT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_bottom_r <= CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        REG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      prev_btn_r  <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        prev_btn_r <= in_btn;
        if (in_mask[0]) begin
          pos_x_r <= new_x;
          pos_y_r <= new_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wheel_r <= in_wheel;
      down_r  <= in_btn[BTN_N-1:0];
    end
    if (emit) begin
      out_kind_r   <= ev_kind;
      out_btn_r    <= ev_btn;
      out_x_r      <= pos_x_r;
      out_y_r      <= pos_y_r;
      out_scroll_r <= ev_scroll;
      out_last_r   <= (pend_left == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - BTN_IDX_W - 3*COORD_W){1'b0}},
                       out_scroll_r, out_y_r, out_x_r, out_btn_r};

endmodule
`default_nettype wire

@@ rtl/ppeg_checker.sv @@
// Port-level checks on the pointer position event generator, bound to the top level.
`default_nettype none
module ppeg_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [ppeg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire [1:0]                        out_tuser,
  input wire                              out_tlast
);
  import ppeg_pkg::*;

  logic [BTN_IDX_W-1:0] btn;
  coord_t               scroll;

  assign btn    = out_tdata[BTN_IDX_W-1:0];
  assign scroll = out_tdata[BTN_IDX_W+3*COORD_W-1:BTN_IDX_W+2*COORD_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output item shown straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_move_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_MOVE |-> btn == '0 && scroll == '0)
    else $error("move item carries a button or scroll amount");

  a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_SCROLL |-> scroll != '0 && btn == '0)
    else $error("scroll item with zero amount or a button");

  a_button_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_DOWN || out_tuser == EV_UP) |->
      scroll == '0 && btn < BTN_IDX_W'(BTN_W))
    else $error("button item with scroll amount or bad index");

endmodule

bind pointer_position_event_generator ppeg_checker u_ppeg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
